[design/ips_pkg.sv]
// Shared types and constants for the incremental prime sieve.
`default_nettype none

package ips_pkg;

   // Field widths of the request and response beats.
   localparam int NUMBER_BITS = 16;
   localparam int COUNT_BITS  = 5;

   // Smallest value that can be prime.
   localparam int FIRST_PRIME = 2;

   // Request commands.
   typedef enum logic [0:0] {
      CMD_TEST  = 1'b0,
      CMD_CLEAR = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [NUMBER_BITS-1:0] number;
   } req_type;

   typedef struct packed {
      logic [NUMBER_BITS-1:0] value;
      logic                   is_prime;
      logic                   overflow;
      logic [COUNT_BITS-1:0]  prime_count;
   } rsp_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

[design/ips_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module ips_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/incremental_prime_sieve.sv]
// Top level of the incremental prime sieve: sequencer, remainder unit and prime table.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  ips_pkg::req_type (cmd, number)
//   rsp_      out        rsp_valid / rsp_ready  ips_pkg::rsp_type (value, is_prime,
//                                               overflow, prime_count)
//
// One request beat is worked on at a time. A clear, a number below two or an
// empty table goes straight from acceptance to the finish state, which loads the
// response register; each stored prime checked adds a table read, then one
// remainder bit per cycle, and the search stops at the first divisor. The next
// beat is taken once the sequencer is back in idle.
// Reset clears sequencer, count and response valid; a waiting response stalls only finish.
`default_nettype none

module incremental_prime_sieve #(
   parameter int NUM_CELLS  = 16,
   parameter int VALUE_BITS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire ips_pkg::req_type req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      ips_pkg::rsp_type rsp_data
);

   // Table addressing and count widths. The count must be able to hold
   // NUM_CELLS itself, so it is one bit wider than the address when the
   // depth is a power of two.
   localparam int IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int CNT_W = $clog2(NUM_CELLS + 1);
   localparam int BIT_W = $clog2(VALUE_BITS);
   // Number of request bits that survive masking to VALUE_BITS.
   localparam int IN_BITS = (VALUE_BITS < ips_pkg::NUMBER_BITS) ?
                            VALUE_BITS : ips_pkg::NUMBER_BITS;

   localparam logic [CNT_W-1:0]      CELLS_CNT   = CNT_W'(NUM_CELLS);
   localparam logic [VALUE_BITS-1:0] FIRST_VALUE = VALUE_BITS'(ips_pkg::FIRST_PRIME);
   localparam logic [BIT_W-1:0]      LAST_BIT    = BIT_W'(VALUE_BITS - 1);

   ips_pkg::state_type    state_ff, state_in;
   logic [VALUE_BITS-1:0] number_ff, number_in;    // candidate under test
   logic [VALUE_BITS-1:0] dividend_ff, dividend_in; // shifts out MSB first
   logic [VALUE_BITS-1:0] rem_ff, rem_in;          // running partial remainder
   logic [BIT_W-1:0]      bit_ff, bit_in;          // remainder bits still to go
   logic [CNT_W-1:0]      idx_ff, idx_in;          // table entry being checked
   logic [CNT_W-1:0]      count_ff, count_in;      // primes stored
   logic                  clear_ff, clear_in;      // current beat is a clear
   logic                  prime_ff, prime_in;      // verdict so far
   logic                  rsp_valid_ff, rsp_valid_in;
   ips_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   logic                  ram_we;
   logic                  ram_re;
   logic [VALUE_BITS-1:0] ram_rd_data;
   logic [VALUE_BITS-1:0] number_masked;
   logic [VALUE_BITS:0]   trial;
   logic [VALUE_BITS:0]   diff;
   logic                  fits;
   logic [VALUE_BITS-1:0] rem_next;
   logic                  slot_free;
   logic                  table_full;

   assign number_masked = VALUE_BITS'(req_data.number[IN_BITS-1:0]);

   // One step of the restoring remainder: bring in the next dividend bit and
   // subtract the divisor when it fits. The partial remainder always stays
   // below the divisor, so it fits back into VALUE_BITS bits.
   assign trial    = {rem_ff, dividend_ff[VALUE_BITS-1]};
   assign fits     = trial >= {1'b0, ram_rd_data};
   assign diff     = trial - {1'b0, ram_rd_data};
   assign rem_next = fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];

   // The output register can take a new response when it is empty or its
   // current beat leaves in this cycle.
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign table_full = (count_ff == CELLS_CNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ips_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      number_ff   <= number_in;
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      bit_ff      <= bit_in;
      idx_ff      <= idx_in;
      clear_ff    <= clear_in;
      prime_ff    <= prime_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      number_in    = number_ff;
      dividend_in  = dividend_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      clear_in     = clear_ff;
      prime_in     = prime_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      case (state_ff)
         ips_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               number_in = number_masked;
               clear_in  = (req_data.cmd == ips_pkg::CMD_CLEAR);
               idx_in    = '0;
               // Numbers below two are never prime; an empty table means
               // any number from two up survives without a check.
               prime_in  = (number_masked >= FIRST_VALUE);
               if (req_data.cmd == ips_pkg::CMD_CLEAR) begin
                  state_in = ips_pkg::ST_FINISH;
               end else if (number_masked >= FIRST_VALUE && count_ff != '0) begin
                  state_in = ips_pkg::ST_READ;
               end else begin
                  state_in = ips_pkg::ST_FINISH;
               end
            end
         end

         ips_pkg::ST_READ: begin
            // Fetch the next stored prime; it is on the RAM output during
            // the whole remainder loop that follows.
            ram_re      = 1'b1;
            dividend_in = number_ff;
            rem_in      = '0;
            bit_in      = LAST_BIT;
            state_in    = ips_pkg::ST_DIVIDE;
         end

         ips_pkg::ST_DIVIDE: begin
            dividend_in = {dividend_ff[VALUE_BITS-2:0], 1'b0};
            rem_in      = rem_next;
            bit_in      = bit_ff - BIT_W'(1);
            if (bit_ff == '0) begin
               if (ram_rd_data != '0 && rem_next == '0) begin
                  // A stored prime divides the number: stop searching.
                  prime_in = 1'b0;
                  state_in = ips_pkg::ST_FINISH;
               end else if (idx_ff + CNT_W'(1) == count_ff) begin
                  state_in = ips_pkg::ST_FINISH;
               end else begin
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = ips_pkg::ST_READ;
               end
            end
         end

         ips_pkg::ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ips_pkg::ST_IDLE;
               if (clear_ff) begin
                  count_in    = '0;
                  rsp_data_in = '0;
               end else begin
                  // A survivor goes into the next free entry, or is flagged
                  // as overflow when every entry is taken.
                  if (prime_ff && !table_full) begin
                     ram_we   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
                  rsp_data_in.value       = ips_pkg::NUMBER_BITS'(number_ff);
                  rsp_data_in.is_prime    = prime_ff;
                  rsp_data_in.overflow    = prime_ff && table_full;
                  rsp_data_in.prime_count = ips_pkg::COUNT_BITS'(count_in);
               end
            end
         end

         default: begin
            state_in = ips_pkg::ST_IDLE;
         end
      endcase
   end

   // Prime table. Only entries below the stored count are ever read, and
   // writes happen only in the finish state, so a read never meets a write
   // to the same entry.
   ips_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (NUM_CELLS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (number_ff),
      .rd_en   (ram_re),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // The remainder loop only ever works on a written table entry.
   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ips_pkg::ST_DIVIDE) |-> (idx_ff < count_ff))
      else $error("table entry checked beyond stored count");

   // The stored count only grows by one or drops to zero on a clear.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + CNT_W'(1) || count_ff == '0))
      else $error("stored count changed by an illegal step");

   // A table write never goes past the last entry.
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (count_ff < CELLS_CNT))
      else $error("table write with a full table");

   // An overflow response is only given once the table is full.
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.overflow) |-> (rsp_data.is_prime && table_full))
      else $error("overflow reported while the table has room");

   // A finished result waits while the output register is still occupied.
   a_finish_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ips_pkg::ST_FINISH && rsp_valid && !rsp_ready) |=>
         (state_ff == ips_pkg::ST_FINISH && $stable(rsp_data)))
      else $error("response register overwritten while stalled");
`endif

endmodule

`default_nettype wire

[tb/incremental_prime_sieve_test.sv]
// Self-checking testbench for the incremental prime sieve: directed table, a back-pressure burst, then random runs.
`timescale 1ns / 1ps

module incremental_prime_sieve_test;

   // The block is built at its default size: sixteen table cells, 16-bit values.
   localparam int SIEVE_CELLS = 16;

   // Random beats to send after the directed table.
   localparam int RANDOM_BEATS = 850;

   // The slowest beat checks all sixteen stored primes. Even with both sides
   // idling as long as they can draw, the whole run stays far below this limit,
   // so the limit only catches a hang.
   localparam int CYCLE_LIMIT = 2_000_000;

   // Quiet cycles after the last response, enough for one worst-case beat.
   localparam int TAIL_CYCLES = 300;

   // Printing stops after this many mismatch lines; counting does not.
   localparam int MAX_REPORTS = 100;

   // One row of the directed table. When has_verdict is set, the expected
   // response is the one typed into the row; otherwise it is predicted.
   typedef struct packed {
      ips_pkg::req_type beat;
      logic             has_verdict;
      ips_pkg::rsp_type verdict;
   } sieve_row_type;

   localparam int DIRECTED_ROWS = 25;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   ips_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   ips_pkg::rsp_type rsp_data;

   // Private copy of the prime table and its fill level.
   logic [ips_pkg::NUMBER_BITS-1:0] known_primes [SIEVE_CELLS];
   int                              known_count = 0;

   // Verdicts for accepted request beats, oldest first.
   ips_pkg::rsp_type predicted_verdicts [$];
   ips_pkg::rsp_type oldest_verdict;

   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  random_sent = 0;

   // Set by the stimulus to switch off random idling on both sides.
   bit  no_idle = 1'b0;

   // Set by the stimulus to ask the receiver for one long hold-off.
   int  rsp_hold_cycles = 0;

   // The directed table. It walks the field extremes, the below-two rule,
   // a prime against an empty table, a number equal to a stored prime, the
   // clear command with a nonzero number, filling all sixteen cells, and
   // primes that arrive while the table is full.
   sieve_row_type directed_rows [DIRECTED_ROWS] = '{
      // Right after reset nothing is stored; zero and one are never prime.
      '{'{ips_pkg::CMD_TEST,  16'd0},     1'b1, '{16'd0,     1'b0, 1'b0, 5'd0}},
      '{'{ips_pkg::CMD_TEST,  16'd1},     1'b1, '{16'd1,     1'b0, 1'b0, 5'd0}},
      // The largest value against an empty table survives and is stored.
      '{'{ips_pkg::CMD_TEST,  16'hFFFF},  1'b1, '{16'hFFFF,  1'b1, 1'b0, 5'd1}},
      // The same value again is divided by itself.
      '{'{ips_pkg::CMD_TEST,  16'hFFFF},  1'b1, '{16'hFFFF,  1'b0, 1'b0, 5'd1}},
      // A clear ignores its number and answers with all zeros.
      '{'{ips_pkg::CMD_CLEAR, 16'hFFFF},  1'b1, '{16'd0,     1'b0, 1'b0, 5'd0}},
      // The first sixteen primes fill the table.
      '{'{ips_pkg::CMD_TEST,  16'd2},     1'b0, '0},
      '{'{ips_pkg::CMD_TEST,  16'd3},     1'b0, '0},
      '{'{ips_pkg::CMD_TEST,  16'd5},     1'b0, '0},
      '{'{ips_pkg::CMD_TEST,  16'd7},     1'b0, '0},
      '{'{ips_pkg::CMD_TEST,  16'd11},    1'b0, '0},
      '{'{ips_pkg::CMD_TEST,  16'd13},    1'b0, '0},
      '{'{ips_pkg::CMD_TEST,  16'd17},    1'b0, '0},
      '{'{ips_pkg::CMD_TEST,  16'd19},    1'b0, '0},
      '{'{ips_pkg::CMD_TEST,  16'd23},    1'b0, '0},
      '{'{ips_pkg::CMD_TEST,  16'd29},    1'b0, '0},
      '{'{ips_pkg::CMD_TEST,  16'd31},    1'b0, '0},
      '{'{ips_pkg::CMD_TEST,  16'd37},    1'b0, '0},
      '{'{ips_pkg::CMD_TEST,  16'd41},    1'b0, '0},
      '{'{ips_pkg::CMD_TEST,  16'd43},    1'b0, '0},
      '{'{ips_pkg::CMD_TEST,  16'd47},    1'b0, '0},
      '{'{ips_pkg::CMD_TEST,  16'd53},    1'b0, '0},
      // With the table full a survivor is flagged and not stored.
      '{'{ips_pkg::CMD_TEST,  16'd59},    1'b1, '{16'd59,    1'b1, 1'b1, 5'd16}},
      '{'{ips_pkg::CMD_TEST,  16'hFFFE},  1'b0, '0},
      // The largest 16-bit prime walks the whole table before it survives.
      '{'{ips_pkg::CMD_TEST,  16'd65521}, 1'b1, '{16'd65521, 1'b1, 1'b1, 5'd16}},
      '{'{ips_pkg::CMD_CLEAR, 16'd0},     1'b1, '{16'd0,     1'b0, 1'b0, 5'd0}}
   };

   incremental_prime_sieve #(
      .NUM_CELLS (SIEVE_CELLS),
      .VALUE_BITS(ips_pkg::NUMBER_BITS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Works out the response to one request beat and updates the private
   // table the way the block updates its own.
   function automatic ips_pkg::rsp_type judge_number(input ips_pkg::req_type beat);
      ips_pkg::rsp_type verdict;
      logic             divided;
      verdict = '0;
      divided = 1'b0;
      if (beat.cmd == ips_pkg::CMD_CLEAR) begin
         known_count = 0;
         return verdict;
      end
      // Stored primes are never below two, so no divisor is ever zero.
      for (int i = 0; i < known_count; i++) begin
         if (beat.number % known_primes[i] == 0) begin
            divided = 1'b1;
         end
      end
      verdict.value = beat.number;
      if (beat.number >= ips_pkg::FIRST_PRIME && !divided) begin
         verdict.is_prime = 1'b1;
         if (known_count < SIEVE_CELLS) begin
            known_primes[known_count] = beat.number;
            known_count++;
         end else begin
            verdict.overflow = 1'b1;
         end
      end
      verdict.prime_count = known_count[ips_pkg::COUNT_BITS-1:0];
      return verdict;
   endfunction

   // Idle cycles before the next beat on either side.
   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, 19);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < MAX_REPORTS) begin
         $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
      end
      mismatch_count++;
   endtask

   // Offers one request beat. It is entered and left at a falling edge, and
   // req_valid gets at most one assignment per falling edge, so a beat that
   // follows with no gap keeps valid high without a glitch.
   task automatic send_beat(input ips_pkg::req_type beat, input logic has_verdict,
                            input ips_pkg::rsp_type verdict);
      int               gap;
      ips_pkg::rsp_type predicted;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      // The predictor always runs so that its table tracks the block, even
      // when the row carries its own typed verdict.
      predicted = judge_number(beat);
      predicted_verdicts.push_back(has_verdict ? verdict : predicted);
      @(negedge clock);
   endtask

   task automatic send_random(input ips_pkg::cmd_type cmd,
                              input logic [ips_pkg::NUMBER_BITS-1:0] number);
      ips_pkg::req_type beat;
      beat.cmd    = cmd;
      beat.number = number;
      send_beat(beat, 1'b0, '0);
      random_sent++;
   endtask

   // The sender stops offering and waits until every response is back.
   // At least one falling edge passes, so req_valid is never assigned
   // twice in the same step.
   task automatic wait_for_verdicts();
      req_valid <= 1'b0;
      do @(negedge clock); while (predicted_verdicts.size() != 0);
   endtask

   // Cycle counter and hang guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("incremental_prime_sieve_test: errors");
         $finish;
      end
   end

   // Receiver. For each response beat it idles a drawn number of cycles
   // with ready low, then holds ready high until the beat is taken. A long
   // hold-off requested by the stimulus replaces one drawn wait.
   initial begin
      int hold;
      do @(negedge clock); while (reset);
      forever begin
         hold = draw_wait();
         if (rsp_hold_cycles > 0) begin
            hold = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Response checker: every beat taken is compared field by field with the
   // oldest verdict still waiting.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_verdicts.size() == 0) begin
            report_mismatch("unexpected response beat, value", rsp_data.value, -1);
         end else begin
            oldest_verdict = predicted_verdicts.pop_front();
            if (rsp_data.value !== oldest_verdict.value) begin
               report_mismatch("value", rsp_data.value, oldest_verdict.value);
            end
            if (rsp_data.is_prime !== oldest_verdict.is_prime) begin
               report_mismatch("is_prime", rsp_data.is_prime, oldest_verdict.is_prime);
            end
            if (rsp_data.overflow !== oldest_verdict.overflow) begin
               report_mismatch("overflow", rsp_data.overflow, oldest_verdict.overflow);
            end
            if (rsp_data.prime_count !== oldest_verdict.prime_count) begin
               report_mismatch("prime_count", rsp_data.prime_count,
                               oldest_verdict.prime_count);
            end
         end
      end
   end

   // Stimulus.
   initial begin
      int run_kind;
      int run_length;
      int candidate;
      int step;
      logic [ips_pkg::NUMBER_BITS-1:0] recent;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_beat(directed_rows[i].beat, directed_rows[i].has_verdict,
                   directed_rows[i].verdict);
      end
      wait_for_verdicts();

      // Back-pressure: once the first response of this burst is taken the
      // receiver holds off for a long stretch while the sender keeps
      // offering beats back to back. The output register and the stalled
      // sequencer fill, and req_ready must drop until the receiver returns.
      // The sender then pauses until every response has come back.
      no_idle = 1'b1;
      rsp_hold_cycles = 1500;
      send_random(ips_pkg::CMD_CLEAR, 16'd0);
      for (int n = 2; n < 10; n++) begin
         send_random(ips_pkg::CMD_TEST, n[ips_pkg::NUMBER_BITS-1:0]);
      end
      wait_for_verdicts();

      // Random part. Most runs are well-formed: usually a clear, then candidates
      // ascending from two (or from a random base) so that the table fills
      // and later primes overflow. The rest is noise: random commands,
      // numbers below two, repeats and numbers out of order.
      recent = 16'd2;
      while (random_sent < RANDOM_BEATS) begin
         run_kind = $urandom_range(0, 9);
         no_idle  = ($urandom_range(0, 3) == 0);
         if (run_kind <= 6) begin
            if ($urandom_range(0, 4) != 0) begin
               send_random(ips_pkg::CMD_CLEAR, ips_pkg::NUMBER_BITS'($urandom));
            end
            candidate  = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 65535) : 2;
            run_length = $urandom_range(8, 70);
            for (int j = 0; j < run_length && candidate <= 65535; j++) begin
               send_random(ips_pkg::CMD_TEST, candidate[ips_pkg::NUMBER_BITS-1:0]);
               recent = candidate[ips_pkg::NUMBER_BITS-1:0];
               step = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 1;
               candidate += step;
            end
         end else begin
            run_length = $urandom_range(4, 16);
            for (int j = 0; j < run_length; j++) begin
               case ($urandom_range(0, 3))
                  0: begin
                     send_random(ips_pkg::CMD_TEST,
                                 ips_pkg::NUMBER_BITS'($urandom_range(0, 3)));
                  end
                  1: begin
                     send_random(ips_pkg::CMD_TEST, recent);
                  end
                  default: begin
                     send_random(($urandom_range(0, 7) == 0) ?
                                 ips_pkg::CMD_CLEAR : ips_pkg::CMD_TEST,
                                 ips_pkg::NUMBER_BITS'($urandom));
                  end
               endcase
            end
         end
         if ($urandom_range(0, 5) == 0) begin
            wait_for_verdicts();
         end
      end

      wait_for_verdicts();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("incremental_prime_sieve_test: clean");
      end else begin
         $display("incremental_prime_sieve_test: errors");
      end
      $finish;
   end

endmodule
